FILE: design/brq_pkg.sv
`timescale 1ns / 1ps

package brq_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int RAD_W     = 2 * DATA_W;
  localparam int ROOT_W    = DATA_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int STEPS     = RAD_W / 2;
  localparam int CNT_W     = 3;

  localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
  localparam logic [CNT_W-1:0] CNT_FOUR = 3'd4;

  localparam logic [ROOT_W-1:0] RMAX = {1'b0, {(ROOT_W-1){1'b1}}};

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // discriminant chain: sqrt of b*b - 4d, b and class ride along
  typedef struct packed {
    logic                     vld;
    logic [RAD_W-1:0]         rad;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
    logic signed [DATA_W-1:0] b;
    logic [CNT_W-1:0]         count;
  } dc_t;

  // root chain: sqrt of y1 and y2 scaled to fixed point
  typedef struct packed {
    logic              vld;
    logic [RAD_W-1:0]  rad1;
    logic [REM_W-1:0]  rem1;
    logic [ROOT_W-1:0] root1;
    logic [RAD_W-1:0]  rad2;
    logic [REM_W-1:0]  rem2;
    logic [ROOT_W-1:0] root2;
    logic [CNT_W-1:0]  count;
  } rc_t;

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] rc;
    logic [DATA_W-1:0] rb;
    logic [DATA_W-1:0] ra;
    logic [CNT_W-1:0]  count;
  } res_t;

  // one restoring square root digit: bring in two radicand bits, try root*4+1
  function automatic sq_t sqrt_step(input logic [REM_W-1:0] rem,
                                    input logic [ROOT_W-1:0] root,
                                    input logic [1:0] bits2);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sq_t              res;
    cur   = {rem[REM_W-3:0], bits2};
    trial = {1'b0, root, 2'b01};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

FILE: design/biquadratic_real_root_solver_top.sv
`timescale 1ns / 1ps

// Real roots of x^4 + b*x^2 + d = 0 for signed Q16.16 coefficients. One beat
// is taken per cycle while the output buffer has room. An accepted beat passes
// a multiply stage, a discriminant stage, a row of 32 square root cells for the
// discriminant, a y stage, a row of 32 cells for the two roots of y = x^2 and
// an output stage. root_count is 0, 2 or 4; unused roots are zero, square roots
// truncate, and roots saturate at +/- the largest positive Q16.16 value. Input
// stays ready while a finished result waits, until the two-entry output buffer
// fills.
module biquadratic_real_root_solver_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // coef_b [31:0], coef_d [63:32]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // root_count, root_a, root_b, root_c, root_e
);

  localparam int DW = brq_pkg::DATA_W;

  logic en;

  // input and product stages
  logic                 s0_vld;
  logic signed [DW-1:0] s0_b;
  logic signed [DW-1:0] s0_d;
  logic [DW-1:0]        s0_ab;
  logic                 s1_vld;
  logic [2*DW-1:0]      s1_bb;
  logic signed [DW-1:0] s1_b;
  logic signed [DW-1:0] s1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= s_axis_tvalid;
      s0_b   <= s_axis_tdata[DW-1:0];
      s0_d   <= s_axis_tdata[2*DW-1:DW];
      s1_vld <= s0_vld;
      s1_bb  <= s0_ab * s0_ab;
      s1_b   <= s0_b;
      s1_d   <= s0_d;
    end
  end

  assign s0_ab = s0_b[DW-1] ? (~s0_b + 1'b1) : s0_b;

  // discriminant and case decision
  logic [DW-1:0]          ad;
  logic [2*DW-1:0]        fd;
  logic                   d_pos;
  logic                   b_pos;
  logic                   disc_neg;
  brq_pkg::dc_t           dc_head_next;
  brq_pkg::dc_t           dc [0:brq_pkg::STEPS];

  always_comb begin
    ad       = s1_d[DW-1] ? (~s1_d + 1'b1) : s1_d;
    fd       = (2*DW)'(ad) << (brq_pkg::FRAC_BITS + 2);
    d_pos    = ~s1_d[DW-1] && (s1_d != '0);
    b_pos    = ~s1_b[DW-1] && (s1_b != '0);
    disc_neg = d_pos && (s1_bb < fd);
    dc_head_next.vld   = s1_vld;
    dc_head_next.rad   = d_pos ? (s1_bb - fd) : (s1_bb + fd);
    dc_head_next.rem   = '0;
    dc_head_next.root  = '0;
    dc_head_next.b     = s1_b;
    if (disc_neg) begin
      dc_head_next.count = brq_pkg::CNT_NONE;
    end else if (!b_pos && !s1_d[DW-1]) begin
      dc_head_next.count = brq_pkg::CNT_FOUR;
    end else if (b_pos && d_pos) begin
      dc_head_next.count = brq_pkg::CNT_NONE;
    end else begin
      dc_head_next.count = brq_pkg::CNT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc[0].vld <= 1'b0;
    end else if (en) begin
      dc[0] <= dc_head_next;
    end
  end

  for (genvar g = 0; g < brq_pkg::STEPS; g++) begin : g_disc
    brq_disc_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (dc[g]),
      .dout (dc[g+1])
    );
  end

  // y1, y2 = floor((-b +- s) / 2), clamped at zero, scaled for the root row
  logic signed [DW:0]   nb;
  logic signed [DW+1:0] sum1;
  logic signed [DW+1:0] sum2;
  logic [DW-1:0]        y1;
  logic [DW-1:0]        y2;
  brq_pkg::rc_t         rc_head_next;
  brq_pkg::rc_t         rc [0:brq_pkg::STEPS];

  always_comb begin
    nb   = -{dc[brq_pkg::STEPS].b[DW-1], dc[brq_pkg::STEPS].b};
    sum1 = {nb[DW], nb} + {2'b00, dc[brq_pkg::STEPS].root};
    sum2 = {nb[DW], nb} - {2'b00, dc[brq_pkg::STEPS].root};
    y1   = sum1[DW+1] ? '0 : sum1[DW:1];
    y2   = sum2[DW+1] ? '0 : sum2[DW:1];
    rc_head_next.vld   = dc[brq_pkg::STEPS].vld;
    rc_head_next.count = dc[brq_pkg::STEPS].count;
    rc_head_next.rem1  = '0;
    rc_head_next.root1 = '0;
    rc_head_next.rem2  = '0;
    rc_head_next.root2 = '0;
    rc_head_next.rad1  = (dc[brq_pkg::STEPS].count == brq_pkg::CNT_NONE) ? '0 :
                         ((2*DW)'(y1) << brq_pkg::FRAC_BITS);
    rc_head_next.rad2  = (dc[brq_pkg::STEPS].count == brq_pkg::CNT_FOUR) ?
                         ((2*DW)'(y2) << brq_pkg::FRAC_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc[0].vld <= 1'b0;
    end else if (en) begin
      rc[0] <= rc_head_next;
    end
  end

  for (genvar g = 0; g < brq_pkg::STEPS; g++) begin : g_root
    brq_root_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (rc[g]),
      .dout (rc[g+1])
    );
  end

  // saturate and mirror
  logic [DW-1:0] r1;
  logic [DW-1:0] r2;
  brq_pkg::res_t res_in;
  brq_pkg::res_t res_out;
  logic          push;

  always_comb begin
    r1 = (rc[brq_pkg::STEPS].root1 > brq_pkg::RMAX) ? brq_pkg::RMAX :
         rc[brq_pkg::STEPS].root1;
    r2 = (rc[brq_pkg::STEPS].root2 > brq_pkg::RMAX) ? brq_pkg::RMAX :
         rc[brq_pkg::STEPS].root2;
    res_in.count = rc[brq_pkg::STEPS].count;
    res_in.ra    = ~r1 + 1'b1;
    res_in.rb    = r1;
    res_in.rc    = ~r2 + 1'b1;
    res_in.re    = r2;
  end

  assign push = en & rc[brq_pkg::STEPS].vld;

  brq_out_buf u_out (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (res_in),
    .room    (en),
    .out_vld (m_axis_tvalid),
    .out_rdy (m_axis_tready),
    .dout    (res_out)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = {5'b0, res_out.re, res_out.rc, res_out.rb, res_out.ra,
                          res_out.count};

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res_out.count == brq_pkg::CNT_NONE ||
                       res_out.count == brq_pkg::CNT_TWO ||
                       res_out.count == brq_pkg::CNT_FOUR))
    else $error("root count out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_out.count != brq_pkg::CNT_FOUR) |->
      (res_out.rc == '0 && res_out.re == '0 &&
       (res_out.count != brq_pkg::CNT_NONE || (res_out.ra == '0 && res_out.rb == '0))))
    else $error("unused root slot not zero");

  a_roots_mirror: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (DW'(res_out.ra + res_out.rb) == '0 &&
                       DW'(res_out.rc + res_out.re) == '0))
    else $error("root pair not symmetric");

  a_stall_has_beat: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held off with no result pending");

endmodule

FILE: design/brq_disc_cell.sv
`timescale 1ns / 1ps

module brq_disc_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  brq_pkg::dc_t  din,
  output brq_pkg::dc_t  dout
);

  brq_pkg::dc_t dout_next;
  brq_pkg::sq_t sq;

  always_comb begin
    sq              = brq_pkg::sqrt_step(din.rem, din.root,
                                         din.rad[brq_pkg::RAD_W-1 -: 2]);
    dout_next       = din;
    dout_next.rad   = {din.rad[brq_pkg::RAD_W-3:0], 2'b00};
    dout_next.rem   = sq.rem;
    dout_next.root  = sq.root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: design/brq_root_cell.sv
`timescale 1ns / 1ps

module brq_root_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  brq_pkg::rc_t  din,
  output brq_pkg::rc_t  dout
);

  brq_pkg::rc_t dout_next;
  brq_pkg::sq_t sq1;
  brq_pkg::sq_t sq2;

  always_comb begin
    sq1             = brq_pkg::sqrt_step(din.rem1, din.root1,
                                         din.rad1[brq_pkg::RAD_W-1 -: 2]);
    sq2             = brq_pkg::sqrt_step(din.rem2, din.root2,
                                         din.rad2[brq_pkg::RAD_W-1 -: 2]);
    dout_next       = din;
    dout_next.rad1  = {din.rad1[brq_pkg::RAD_W-3:0], 2'b00};
    dout_next.rem1  = sq1.rem;
    dout_next.root1 = sq1.root;
    dout_next.rad2  = {din.rad2[brq_pkg::RAD_W-3:0], 2'b00};
    dout_next.rem2  = sq2.rem;
    dout_next.root2 = sq2.root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

FILE: design/brq_out_buf.sv
`timescale 1ns / 1ps

module brq_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brq_pkg::res_t  din,
  output logic           room,
  output logic           out_vld,
  input  logic           out_rdy,
  output brq_pkg::res_t  dout
);

  logic          main_vld;
  logic          skid_vld;
  brq_pkg::res_t skid;
  logic          pop;

  assign pop     = main_vld & out_rdy;
  assign room    = ~skid_vld;
  assign out_vld = main_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      // upstream is held while the skid beat is parked
      if (pop) begin
        dout     <= skid;
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (!main_vld || pop) begin
        dout     <= din;
        main_vld <= 1'b1;
      end else begin
        skid     <= din;
        skid_vld <= 1'b1;
      end
    end else if (pop) begin
      main_vld <= 1'b0;
    end
  end

endmodule

FILE: tb/sv/biquadratic_real_root_solver_top_tb.sv
`timescale 1ns / 1ps

module biquadratic_real_root_solver_top_tb;

  localparam int ONE = 65536;  // 1.0 in Q16.16
  localparam logic signed [31:0] BMIN = 32'sh8000_0000;
  localparam logic signed [31:0] BMAX = 32'sh7FFF_FFFF;
  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic signed [31:0] b;
    logic signed [31:0] d;
    logic               typed;
    brq_pkg::res_t      want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;     // coef_b [31:0], coef_d [63:32]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;          // root_count, root_a, root_b, root_c, root_e

  brq_pkg::res_t roots_due[$];
  row_t          sweep_rows[$];
  int            bad_results = 0;
  int            send_idle = 0;
  int            recv_stall = 0;
  int            stall_hold = 0;
  brq_pkg::res_t got_roots;
  brq_pkg::res_t want_now;

  biquadratic_real_root_solver_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor of the square root of a wide radicand
  function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  // square root of a non-negative Q16.16 value, clamped to the positive limit
  function automatic logic [31:0] fixed_sqrt(input longint y);
    logic [63:0] r;
    r = floor_sqrt({64'd0, y} << brq_pkg::FRAC_BITS);
    if (r > {32'd0, brq_pkg::RMAX}) r = {32'd0, brq_pkg::RMAX};
    return r[31:0];
  endfunction

  function automatic brq_pkg::res_t pack_roots(input logic [brq_pkg::CNT_W-1:0] count,
                                               input logic [31:0] r1,
                                               input logic [31:0] r2);
    brq_pkg::res_t res;
    res.count = count;
    res.ra    = -r1;
    res.rb    = r1;
    res.rc    = -r2;
    res.re    = r2;
    return res;
  endfunction

  function automatic brq_pkg::res_t solve_roots(input logic signed [31:0] b,
                                                input logic signed [31:0] d);
    longint      bl, dl, s, y1, y2;
    logic [127:0] bb, fd, disc;
    bl = longint'(b);
    dl = longint'(d);
    bb = 128'((bl < 0) ? -bl : bl);
    bb = bb * bb;
    fd = 128'((dl < 0) ? -dl : dl);
    fd = fd << (brq_pkg::FRAC_BITS + 2);
    if (dl > 0 && bb < fd) return pack_roots(brq_pkg::CNT_NONE, '0, '0);
    disc = (dl > 0) ? bb - fd : bb + fd;
    s  = longint'(floor_sqrt(disc));
    y1 = (-bl + s) >>> 1;
    y2 = (-bl - s) >>> 1;
    // class comes from the input signs, not from the rounded y values
    if (bl <= 0 && dl >= 0)
      return pack_roots(brq_pkg::CNT_FOUR, fixed_sqrt(y1),
                        fixed_sqrt(y2 < 0 ? 0 : y2));
    if (bl > 0 && dl > 0) return pack_roots(brq_pkg::CNT_NONE, '0, '0);
    return pack_roots(brq_pkg::CNT_TWO, fixed_sqrt(y1 < 0 ? 0 : y1), '0);
  endfunction

  task automatic add_row(input logic signed [31:0] b, input logic signed [31:0] d,
                         input logic typed, input brq_pkg::res_t want);
    sweep_rows.push_back('{b, d, typed, want});
  endtask

  task automatic send_coefs(input logic signed [31:0] b, input logic signed [31:0] d,
                            input logic typed, input brq_pkg::res_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, b};
    do @(posedge clk); while (!s_axis_tready);
    roots_due.push_back(typed ? want : solve_roots(b, d));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed coefficient pairs, with some raw noise
  task automatic random_coefs(output logic signed [31:0] b, output logic signed [31:0] d);
    longint u, v, bs;
    case ($urandom_range(0, 3))
      0: begin
        b = $urandom;
        d = $urandom;
      end
      1: begin
        b = $urandom_range(0, 1 << 21) - (1 << 20);
        d = $urandom_range(0, 1 << 21) - (1 << 20);
      end
      2: begin
        // four real roots: b = -(y1 + y2), d = y1 * y2
        u = longint'($urandom_range(0, 1 << 23));
        v = longint'($urandom_range(0, 1 << 23));
        b = 32'(-(u + v));
        d = 32'((u * v) >>> 16);
      end
      default: begin
        // hug the zero-discriminant boundary
        bs = longint'($urandom_range(0, 1 << 24));
        if ($urandom_range(0, 1) != 0) bs = -bs;
        b = 32'(bs);
        d = 32'(((bs * bs) >>> 18) + $urandom_range(0, 8) - 4);
      end
    endcase
  endtask

  always begin
    @(posedge clk);
    if (stall_hold > 0) begin
      m_axis_tready <= 1'b0;
      repeat (stall_hold) @(posedge clk);
      stall_hold = 0;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_roots = m_axis_tdata[$bits(brq_pkg::res_t)-1:0];
      if (roots_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected beat: count %0d a %h b %h c %h e %h", got_roots.count,
                   got_roots.ra, got_roots.rb, got_roots.rc, got_roots.re);
      end else begin
        want_now = roots_due.pop_front();
        if (got_roots.count !== want_now.count || got_roots.ra !== want_now.ra ||
            got_roots.rb !== want_now.rb || got_roots.rc !== want_now.rc ||
            got_roots.re !== want_now.re) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: exp %0d %h %h %h %h / got %0d %h %h %h %h",
                     want_now.count, want_now.ra, want_now.rb, want_now.rc, want_now.re,
                     got_roots.count, got_roots.ra, got_roots.rb, got_roots.rc, got_roots.re);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic signed [31:0] b, d;
    row_t               row;

    // readable cases carry their roots; the rest go through the predictor
    add_row(0, 0, 1'b1, pack_roots(brq_pkg::CNT_FOUR, '0, '0));
    add_row(ONE, ONE, 1'b1, pack_roots(brq_pkg::CNT_NONE, '0, '0));
    add_row(0, 1, 1'b1, pack_roots(brq_pkg::CNT_NONE, '0, '0));
    add_row(-5 * ONE, 4 * ONE, 1'b1, pack_roots(brq_pkg::CNT_FOUR, 2 * ONE, ONE));
    add_row(-2 * ONE, ONE, 1'b1, pack_roots(brq_pkg::CNT_FOUR, ONE, ONE));
    add_row(2 * ONE, ONE, 1'b1, pack_roots(brq_pkg::CNT_NONE, '0, '0));
    add_row(ONE, 0, 1'b1, pack_roots(brq_pkg::CNT_TWO, '0, '0));
    add_row(-ONE, 0, 1'b1, pack_roots(brq_pkg::CNT_FOUR, ONE, '0));
    add_row(BMAX, BMAX, 1'b1, pack_roots(brq_pkg::CNT_NONE, '0, '0));
    add_row(-ONE, BMAX, 1'b1, pack_roots(brq_pkg::CNT_NONE, '0, '0));
    add_row(BMAX, 0, 1'b1, pack_roots(brq_pkg::CNT_TWO, '0, '0));
    add_row(0, -4 * ONE, 1'b0, '0);
    add_row(BMIN, BMIN, 1'b0, '0);
    add_row(BMIN, BMAX, 1'b0, '0);
    add_row(BMAX, BMIN, 1'b0, '0);
    add_row(BMIN, 0, 1'b0, '0);
    add_row(0, BMIN, 1'b0, '0);
    add_row(-BMAX, BMAX, 1'b0, '0);
    add_row(-1, 1, 1'b0, '0);
    add_row(-3 * ONE, 2 * ONE, 1'b0, '0);
    add_row(5 * ONE, -ONE, 1'b0, '0);
    add_row(0, -1, 1'b0, '0);
    add_row(1, -1, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (sweep_rows[i]) begin
      row = sweep_rows[i];
      send_coefs(row.b, row.d, row.typed, row.want);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  stall_hold = HOLD_CYCLES; end
        1: begin send_idle = 86; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 86; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_coefs(b, d);
        send_coefs(b, d, 1'b0, '0);
      end
      // hold off until every result is back
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_results == 0 && roots_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
